>>> hdl/lhif_pkg.sv
// shared types and constants for the led hue / intensity fader
// no dependencies; used by lhif_div and led_hue_intensity_fader
package lhif_pkg;

   localparam int DVD_W = 34;
   localparam int DVS_W = 17;
   localparam int CNT_W = 6;

   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_SET_COLOR = 3'd1;
   localparam logic [2:0] OP_SET_INT   = 3'd2;
   localparam logic [2:0] OP_FADE_INT  = 3'd3;
   localparam logic [2:0] OP_FADE_HUE  = 3'd4;
   localparam logic [2:0] OP_OSC       = 3'd5;
   localparam logic [2:0] OP_STOP      = 3'd6;

   localparam logic [0:0] CSR_DIM_ENABLE = 1'd0;
   localparam logic [0:0] CSR_TICK_MS    = 1'd1;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] hue_value;
      logic [7:0]  intensity_value;
      logic [15:0] fade_ms;
      logic        shortest_path;
      logic [7:0]  cycle_count;
   } req_type;

   typedef struct packed {
      logic [7:0] hue_now;
      logic [7:0] intensity_now;
      logic [7:0] shown_brightness;
      logic       hue_fading;
      logic       intensity_fading;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INT_CHK,
      ST_HUE_CHK,
      ST_ADD,
      ST_LAUNCH,
      ST_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      JOB_INT,
      JOB_HUE,
      JOB_TICKS_INT,
      JOB_TICKS_HUE
   } job_type;

endpackage

>>> hdl/lhif_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on lhif_pkg for operand widths
module lhif_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lhif_pkg::DVD_W-1:0]  dividend,
   input  logic [lhif_pkg::DVS_W-1:0]  divisor,
   output logic                        done,
   output logic [lhif_pkg::DVD_W-1:0]  quotient
);

   logic [lhif_pkg::DVD_W-1:0] dvd_ff, dvd_in;
   logic [lhif_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic [lhif_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [lhif_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       done_ff, done_in;
   logic [lhif_pkg::DVS_W:0]   rem_sh;
   logic [lhif_pkg::DVS_W:0]   rem_sub;
   logic                       ge;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[lhif_pkg::DVD_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      ge      = rem_sh >= {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
         cnt_in = lhif_pkg::CNT_W'(lhif_pkg::DVD_W);
      end else if (cnt_ff != '0) begin
         dvd_in = {dvd_ff[lhif_pkg::DVD_W-2:0], ge};
         rem_in = ge ? rem_sub[lhif_pkg::DVS_W-1:0] : rem_sh[lhif_pkg::DVS_W-1:0];
         cnt_in = cnt_ff - lhif_pkg::CNT_W'(1);
         done_in = (cnt_ff == lhif_pkg::CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

>>> hdl/led_hue_intensity_fader.sv
// top level of the led hue / intensity fader: command sequencer and fade state
// depends on lhif_pkg and lhif_div
//
// One command beat in, one status beat out. Every division (fade length in
// ticks and each interpolation step) runs through a single serial divider;
// each interpolation step is fed by a shared 16x16 multiplier. A division
// holds the sequencer until all 34 shift steps of the divider are done. The
// block takes no new command until the status beat of the current one is in
// the output register, so a stalled status beat delays the next command.
module led_hue_intensity_fader (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lhif_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lhif_pkg::rsp_type    rsp_data,
   input  logic                 csr_we,
   input  logic [0:0]           csr_index,
   input  logic [7:0]           csr_wdata
);

   // configuration
   logic       dim_ff;
   logic [7:0] tick_ms_ff;

   // sequencer and held command
   lhif_pkg::state_type state_ff, state_in;
   lhif_pkg::job_type   job_ff, job_in;
   lhif_pkg::req_type   cmd_ff, cmd_in;

   // fade state
   logic [7:0]  cur_hue_ff, cur_hue_in;
   logic [7:0]  cur_int_ff, cur_int_in;
   logic        int_act_ff, int_act_in;
   logic [7:0]  int_start_ff, int_start_in;
   logic [7:0]  int_goal_ff, int_goal_in;
   logic [8:0]  int_span_ff, int_span_in;
   logic [15:0] int_total_ff, int_total_in;
   logic [15:0] int_el_ff, int_el_in;
   logic        hue_act_ff, hue_act_in;
   logic [7:0]  hue_start_ff, hue_start_in;
   logic [7:0]  hue_goal_ff, hue_goal_in;
   logic [15:0] hue_span_ff, hue_span_in;
   logic [15:0] hue_total_ff, hue_total_in;
   logic [15:0] hue_el_ff, hue_el_in;

   // shared datapath
   logic [31:0] prod_ff, prod_in;
   logic [lhif_pkg::DVD_W-1:0] dvd_ff, dvd_in;
   logic [lhif_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic        div_start;
   logic        div_done;
   logic [lhif_pkg::DVD_W-1:0] div_q;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   lhif_pkg::rsp_type rsp_ff, rsp_in;

   // helper values
   logic [15:0] mul_a, mul_b;
   logic [15:0] job_ticks;
   logic [7:0]  tick_div;
   logic [8:0]  int_d;
   logic [15:0] hue_tgt, hd, hd1, hd2, m0, m1, m2, hue_d;
   logic        hue_go, int_go;
   logic [7:0]  dim_x;
   logic [16:0] dim_sq;
   logic [7:0]  shown;
   logic [7:0]  r8;

   function automatic logic [15:0] mag16(input logic [15:0] v);
      mag16 = v[15] ? 16'(-v) : v;
   endfunction

   lhif_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_ff),
      .divisor  (dvs_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      // interval of zero behaves as one
      tick_div = (tick_ms_ff == 8'd0) ? 8'd1 : tick_ms_ff;

      // intensity fade delta
      int_d  = {1'b0, cmd_ff.intensity_value} - {1'b0, cur_int_ff};
      int_go = (cmd_ff.fade_ms != 16'd0) && (int_d != 9'd0);

      // hue fade delta with optional shortest wrap
      hue_tgt = (cmd_ff.op == lhif_pkg::OP_FADE_HUE) ? cmd_ff.hue_value
                                                    : {cmd_ff.cycle_count, cur_hue_ff};
      hd  = hue_tgt - {8'd0, cur_hue_ff};
      hd1 = hd + 16'd256;
      hd2 = hd - 16'd256;
      m0  = mag16(hd);
      m1  = mag16(hd1);
      m2  = mag16(hd2);
      hue_d = hd;
      if (cmd_ff.op == lhif_pkg::OP_FADE_HUE && cmd_ff.shortest_path) begin
         if (m1 <= m0 && m1 < m2) begin
            hue_d = hd1;
         end else if (m2 <= m0 && m2 < m1) begin
            hue_d = hd2;
         end
      end
      hue_go = (cmd_ff.fade_ms != 16'd0) && (hd != 16'd0)
               && (cmd_ff.op == lhif_pkg::OP_FADE_HUE || cmd_ff.cycle_count != 8'd0);

      // shared multiplier operands
      if (state_ff == lhif_pkg::ST_INT_CHK) begin
         mul_a = int_el_ff;
         mul_b = {8'd0, int_span_ff[8] ? 8'(-int_span_ff) : int_span_ff[7:0]};
      end else begin
         mul_a = hue_el_ff;
         mul_b = mag16(hue_span_ff);
      end
      job_ticks = (job_ff == lhif_pkg::JOB_INT) ? int_total_ff : hue_total_ff;
      r8 = div_q[7:0];

      // perceptual dimming curve
      dim_x  = 8'd127 + 8'((9'(cur_int_ff) + 9'd1) >> 1);
      dim_sq = 17'(dim_x) * (17'(dim_x) + 17'd1);
      if (!dim_ff) begin
         shown = cur_int_ff;
      end else if (cur_int_ff == 8'd0) begin
         shown = 8'd0;
      end else begin
         shown = dim_sq[15:8];
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      cmd_in       = cmd_ff;
      cur_hue_in   = cur_hue_ff;
      cur_int_in   = cur_int_ff;
      int_act_in   = int_act_ff;
      int_start_in = int_start_ff;
      int_goal_in  = int_goal_ff;
      int_span_in  = int_span_ff;
      int_total_in = int_total_ff;
      int_el_in    = int_el_ff;
      hue_act_in   = hue_act_ff;
      hue_start_in = hue_start_ff;
      hue_goal_in  = hue_goal_ff;
      hue_span_in  = hue_span_ff;
      hue_total_in = hue_total_ff;
      hue_el_in    = hue_el_ff;
      prod_in      = prod_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      req_stall    = (state_ff != lhif_pkg::ST_IDLE);

      case (state_ff)
         lhif_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data;
               state_in = lhif_pkg::ST_EXEC;
            end
         end
         lhif_pkg::ST_EXEC: begin
            state_in = lhif_pkg::ST_OUT;
            // fade length numerator 2*dur+iv over 2*iv
            dvd_in = lhif_pkg::DVD_W'({1'b0, cmd_ff.fade_ms, 1'b0} + 18'(tick_div));
            dvs_in = lhif_pkg::DVS_W'({tick_div, 1'b0});
            case (cmd_ff.op)
               lhif_pkg::OP_TICK: begin
                  // counters saturate at full scale
                  if (int_el_ff != 16'hFFFF) int_el_in = int_el_ff + 16'd1;
                  if (hue_el_ff != 16'hFFFF) hue_el_in = hue_el_ff + 16'd1;
                  state_in = lhif_pkg::ST_INT_CHK;
               end
               lhif_pkg::OP_SET_COLOR: begin
                  cur_hue_in = cmd_ff.hue_value[7:0];
                  cur_int_in = cmd_ff.intensity_value;
               end
               lhif_pkg::OP_SET_INT: begin
                  if (!int_act_ff) cur_int_in = cmd_ff.intensity_value;
               end
               lhif_pkg::OP_FADE_INT: begin
                  if (int_go) begin
                     int_act_in   = 1'b1;
                     int_start_in = cur_int_ff;
                     int_goal_in  = cmd_ff.intensity_value;
                     int_span_in  = int_d;
                     int_el_in    = 16'd0;
                     job_in       = lhif_pkg::JOB_TICKS_INT;
                     state_in     = lhif_pkg::ST_LAUNCH;
                  end
               end
               lhif_pkg::OP_FADE_HUE, lhif_pkg::OP_OSC: begin
                  if (hue_go) begin
                     hue_act_in   = 1'b1;
                     hue_start_in = cur_hue_ff;
                     hue_goal_in  = hue_tgt[7:0];
                     hue_span_in  = hue_d;
                     hue_el_in    = 16'd0;
                     job_in       = lhif_pkg::JOB_TICKS_HUE;
                     state_in     = lhif_pkg::ST_LAUNCH;
                  end
               end
               lhif_pkg::OP_STOP: begin
                  int_act_in = 1'b0;
                  hue_act_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         lhif_pkg::ST_INT_CHK: begin
            state_in = lhif_pkg::ST_HUE_CHK;
            if (int_act_ff) begin
               if (int_el_ff < int_total_ff) begin
                  prod_in  = 32'(mul_a) * 32'(mul_b);
                  job_in   = lhif_pkg::JOB_INT;
                  state_in = lhif_pkg::ST_ADD;
               end else begin
                  int_act_in = 1'b0;
                  cur_int_in = int_goal_ff;
               end
            end
         end
         lhif_pkg::ST_HUE_CHK: begin
            state_in = lhif_pkg::ST_OUT;
            if (hue_act_ff) begin
               if (hue_el_ff < hue_total_ff) begin
                  prod_in  = 32'(mul_a) * 32'(mul_b);
                  job_in   = lhif_pkg::JOB_HUE;
                  state_in = lhif_pkg::ST_ADD;
               end else begin
                  hue_act_in = 1'b0;
                  cur_hue_in = hue_goal_ff;
               end
            end
         end
         lhif_pkg::ST_ADD: begin
            // round half away: (2*num + ticks) / (2*ticks)
            dvd_in   = {1'b0, prod_ff, 1'b0} + lhif_pkg::DVD_W'(job_ticks);
            dvs_in   = {job_ticks, 1'b0};
            state_in = lhif_pkg::ST_LAUNCH;
         end
         lhif_pkg::ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = lhif_pkg::ST_WAIT;
         end
         lhif_pkg::ST_WAIT: begin
            if (div_done) begin
               case (job_ff)
                  lhif_pkg::JOB_INT: begin
                     cur_int_in = int_span_ff[8] ? int_start_ff - r8 : int_start_ff + r8;
                     state_in   = lhif_pkg::ST_HUE_CHK;
                  end
                  lhif_pkg::JOB_HUE: begin
                     cur_hue_in = hue_span_ff[15] ? hue_start_ff - r8 : hue_start_ff + r8;
                     state_in   = lhif_pkg::ST_OUT;
                  end
                  lhif_pkg::JOB_TICKS_INT: begin
                     int_total_in = div_q[15:0];
                     state_in     = lhif_pkg::ST_OUT;
                  end
                  default: begin
                     hue_total_in = div_q[15:0];
                     state_in     = lhif_pkg::ST_OUT;
                  end
               endcase
            end
         end
         lhif_pkg::ST_OUT: begin
            // wait for the output slot to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_in.hue_now          = cur_hue_ff;
               rsp_in.intensity_now    = cur_int_ff;
               rsp_in.shown_brightness = shown;
               rsp_in.hue_fading       = hue_act_ff;
               rsp_in.intensity_fading = int_act_ff;
               state_in                = lhif_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lhif_pkg::ST_IDLE;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff     <= 1'b1;
         tick_ms_ff <= 8'd16;
      end else if (csr_we) begin
         case (csr_index)
            lhif_pkg::CSR_DIM_ENABLE: dim_ff     <= csr_wdata[0];
            lhif_pkg::CSR_TICK_MS:    tick_ms_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // state and datapath registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      job_ff  <= job_in;
      prod_ff <= prod_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= lhif_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_hue_ff   <= '0;
         cur_int_ff   <= '0;
         int_act_ff   <= 1'b0;
         int_start_ff <= '0;
         int_goal_ff  <= '0;
         int_span_ff  <= '0;
         int_total_ff <= '0;
         int_el_ff    <= '0;
         hue_act_ff   <= 1'b0;
         hue_start_ff <= '0;
         hue_goal_ff  <= '0;
         hue_span_ff  <= '0;
         hue_total_ff <= '0;
         hue_el_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_hue_ff   <= cur_hue_in;
         cur_int_ff   <= cur_int_in;
         int_act_ff   <= int_act_in;
         int_start_ff <= int_start_in;
         int_goal_ff  <= int_goal_in;
         int_span_ff  <= int_span_in;
         int_total_ff <= int_total_in;
         int_el_ff    <= int_el_in;
         hue_act_ff   <= hue_act_in;
         hue_start_ff <= hue_start_in;
         hue_goal_ff  <= hue_goal_in;
         hue_span_ff  <= hue_span_in;
         hue_total_ff <= hue_total_in;
         hue_el_ff    <= hue_el_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> verif/lhif_checker.sv
`timescale 1ns / 1ps
// checker for the led hue / intensity fader: predicts each status beat and compares
// depends on lhif_pkg; instantiated by tb_led_hue_intensity_fader
module lhif_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  lhif_pkg::req_type    req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  lhif_pkg::rsp_type    rsp_data,
   input  logic                 csr_we,
   input  logic [0:0]           csr_index,
   input  logic [7:0]           csr_wdata,
   output int                   fail_count,
   output int                   pending_count
);

   logic       dim_on;
   logic [7:0] tick_ms;
   logic [7:0] hue_q, int_q;
   logic       int_run, hue_run;
   logic [7:0] int_from, int_to, hue_from, hue_to;
   int         int_swing, hue_swing;
   logic [15:0] int_len, int_cnt, hue_len, hue_cnt;

   lhif_pkg::rsp_type status_queue[$];

   assign pending_count = status_queue.size();

   function automatic int wrap_s16(int v);
      logic [15:0] u;
      u = v[15:0];
      return u[15] ? int'(u) - 65536 : int'(u);
   endfunction

   function automatic int absval(int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [15:0] ticks_for(logic [15:0] dur);
      longint iv;
      iv = (tick_ms == 0) ? 1 : tick_ms;
      return 16'((2 * longint'(dur) + iv) / (2 * iv));
   endfunction

   function automatic logic [7:0] blend(logic [7:0] from, int delta,
                                        logic [15:0] cnt, logic [15:0] len);
      longint prod, q;
      logic [15:0] r;
      prod = longint'(cnt) * absval(delta);
      q = (2 * prod + len) / (2 * longint'(len));
      r = q[15:0];
      return delta < 0 ? 8'(from - r) : 8'(from + r);
   endfunction

   task automatic launch_hue(logic [15:0] goal, logic [15:0] dur, logic shortest);
      int d, up, dn;
      if (dur == 0) return;
      d = wrap_s16(int'(goal) - hue_q);
      if (d == 0) return;
      if (shortest) begin
         up = wrap_s16(int'(goal) + 256 - hue_q);
         dn = wrap_s16(int'(goal) - 256 - hue_q);
         if (absval(up) <= absval(d) && absval(up) < absval(dn)) d = up;
         else if (absval(dn) <= absval(d) && absval(dn) < absval(up)) d = dn;
      end
      hue_run = 1; hue_from = hue_q; hue_to = goal[7:0];
      hue_swing = d; hue_len = ticks_for(dur); hue_cnt = 0;
   endtask

   task automatic apply_command(lhif_pkg::req_type c);
      lhif_pkg::rsp_type s;
      int d;
      logic [7:0] x8;
      int x;
      case (c.op)
         lhif_pkg::OP_TICK: begin
            if (hue_cnt != 16'hFFFF) hue_cnt++;
            if (int_cnt != 16'hFFFF) int_cnt++;
            if (int_run) begin
               if (int_cnt < int_len) int_q = blend(int_from, int_swing, int_cnt, int_len);
               else begin
                  int_run = 0; int_q = int_to;
               end
            end
            if (hue_run) begin
               if (hue_cnt < hue_len) hue_q = blend(hue_from, hue_swing, hue_cnt, hue_len);
               else begin
                  hue_run = 0; hue_q = hue_to;
               end
            end
         end
         lhif_pkg::OP_SET_COLOR: begin
            hue_q = c.hue_value[7:0]; int_q = c.intensity_value;
         end
         lhif_pkg::OP_SET_INT: if (!int_run) int_q = c.intensity_value;
         lhif_pkg::OP_FADE_INT: begin
            d = int'(c.intensity_value) - int'(int_q);
            if (c.fade_ms != 0 && d != 0) begin
               int_run = 1; int_from = int_q; int_to = c.intensity_value;
               int_swing = d; int_len = ticks_for(c.fade_ms); int_cnt = 0;
            end
         end
         lhif_pkg::OP_FADE_HUE: launch_hue(c.hue_value, c.fade_ms, c.shortest_path);
         lhif_pkg::OP_OSC: if (c.cycle_count != 0)
            launch_hue(16'(int'(c.cycle_count) * 256 + hue_q), c.fade_ms, 1'b0);
         lhif_pkg::OP_STOP: begin
            int_run = 0; hue_run = 0;
         end
         default: ;
      endcase
      s.hue_now = hue_q;
      s.intensity_now = int_q;
      if (!dim_on) s.shown_brightness = int_q;
      else if (int_q == 0) s.shown_brightness = 0;
      else begin
         x = 127 + (int'(int_q) + 1) / 2;
         x8 = 8'((x * (x + 1)) >> 8);
         s.shown_brightness = x8;
      end
      s.hue_fading = hue_run;
      s.intensity_fading = int_run;
      status_queue.push_back(s);
   endtask

   always @(posedge clock) begin
      lhif_pkg::rsp_type want;
      if (reset) begin
         dim_on = 1; tick_ms = 16; hue_q = 0; int_q = 0;
         int_run = 0; hue_run = 0; int_from = 0; int_to = 0; hue_from = 0; hue_to = 0;
         int_swing = 0; hue_swing = 0; int_len = 0; int_cnt = 0; hue_len = 0; hue_cnt = 0;
         status_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == lhif_pkg::CSR_DIM_ENABLE) dim_on = csr_wdata[0];
            else if (csr_index == lhif_pkg::CSR_TICK_MS) tick_ms = csr_wdata;
         end
         // status beat first: its expectation was queued on an earlier edge
         if (rsp_valid && !rsp_stall) begin
            if (status_queue.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected status beat %p", $time, rsp_data);
            end else begin
               want = status_queue.pop_front();
               if (rsp_data.hue_now !== want.hue_now ||
                   rsp_data.intensity_now !== want.intensity_now ||
                   rsp_data.shown_brightness !== want.shown_brightness ||
                   rsp_data.hue_fading !== want.hue_fading ||
                   rsp_data.intensity_fading !== want.intensity_fading) begin
                  fail_count++;
                  $display("%0t: status mismatch expected %p actual %p", $time, want, rsp_data);
               end
            end
         end
         if (req_valid && !req_stall) apply_command(req_data);
      end
   end

endmodule

>>> verif/tb_led_hue_intensity_fader.sv
`timescale 1ns / 1ps
// testbench top for the led hue / intensity fader: clock, reset, command stimulus, verdict
// depends on lhif_pkg, led_hue_intensity_fader and lhif_checker
module tb_led_hue_intensity_fader;

   logic    clock, reset;
   logic    req_valid, req_stall, rsp_valid, rsp_stall;
   lhif_pkg::req_type req_data;
   lhif_pkg::rsp_type rsp_data;
   logic    csr_we;
   logic [0:0] csr_index;
   logic [7:0] csr_wdata;
   int      fail_count, pending_count;
   int      cycle_no;
   bit      quiet_mode;   // no random idling on either side
   bit      hold_off_go;  // ask the receiver for one long stall

   localparam int CYCLE_LIMIT = 400000;

   led_hue_intensity_fader dut (.*);
   lhif_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog: ends the run with an error once the cycle limit is passed
   always @(posedge clock) begin
      cycle_no++;
      if (cycle_no > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int n;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            rsp_stall <= 1;
            for (n = 0; n < 300; n++) @(negedge clock);
            hold_off_go = 0;
            rsp_stall <= 0;
         end else
            rsp_stall <= !quiet_mode && ($urandom_range(99) < 8);
      end
   end

   task automatic csr_write(logic [0:0] idx, logic [7:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
   endtask

   // send one command beat; random idle cycles ahead of it
   task automatic send_beat(lhif_pkg::req_type c);
      while (!quiet_mode && $urandom_range(99) < 8) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_data <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock); // let any beat still in flight settle
   endtask

   function automatic lhif_pkg::req_type make_cmd(logic [2:0] op, logic [15:0] hv,
                                                  logic [7:0] iv, logic [15:0] dur,
                                                  logic sp, logic [7:0] cyc);
      lhif_pkg::req_type c;
      c.op = op; c.hue_value = hv; c.intensity_value = iv;
      c.fade_ms = dur; c.shortest_path = sp; c.cycle_count = cyc;
      return c;
   endfunction

   // mostly short fades and ticks so fades run to completion often
   function automatic lhif_pkg::req_type rand_cmd();
      lhif_pkg::req_type c;
      int pick;
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      c = raw[$bits(lhif_pkg::req_type)-1:0];
      pick = $urandom_range(99);
      if (pick < 55) c.op = lhif_pkg::OP_TICK;
      else if (pick < 62) c.op = lhif_pkg::OP_SET_COLOR;
      else if (pick < 68) c.op = lhif_pkg::OP_SET_INT;
      else if (pick < 78) c.op = lhif_pkg::OP_FADE_INT;
      else if (pick < 88) c.op = lhif_pkg::OP_FADE_HUE;
      else if (pick < 93) c.op = lhif_pkg::OP_OSC;
      else if (pick < 97) c.op = lhif_pkg::OP_STOP;
      else c.op = 3'd7;
      if ($urandom_range(9) < 8) c.fade_ms = 16'($urandom_range(400));
      if ($urandom_range(9) < 7) c.cycle_count = 8'($urandom_range(3));
      return c;
   endfunction

   initial begin
      int k, phase;
      logic [7:0] tick_set [4];
      tick_set = '{8'd1, 8'd255, 8'd16, 8'd7};
      cycle_no = 0; quiet_mode = 0; hold_off_go = 0;
      req_valid = 0; req_data = '0; csr_we = 0; csr_index = 0; csr_wdata = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: field extremes, every op, special cases
      send_beat(make_cmd(lhif_pkg::OP_TICK, 16'hFFFF, 8'hFF, 16'hFFFF, 1, 8'hFF));
      send_beat(make_cmd(lhif_pkg::OP_SET_COLOR, 16'hFFF0, 8'd0, 0, 0, 0));
      send_beat(make_cmd(lhif_pkg::OP_FADE_INT, 0, 8'd200, 16'd0, 0, 0));   // zero duration
      send_beat(make_cmd(lhif_pkg::OP_FADE_INT, 0, 8'd0, 16'd100, 0, 0));   // zero delta
      send_beat(make_cmd(lhif_pkg::OP_FADE_INT, 0, 8'd255, 16'd50, 0, 0));
      send_beat(make_cmd(lhif_pkg::OP_SET_INT, 0, 8'd9, 0, 0, 0));           // ignored mid fade
      send_beat(make_cmd(lhif_pkg::OP_FADE_HUE, 16'h0010, 0, 16'd40, 1, 0)); // short way
      send_beat(make_cmd(lhif_pkg::OP_SET_COLOR, 16'h0033, 8'd128, 0, 0, 0)); // during fade
      for (k = 0; k < 6; k++) send_beat(make_cmd(lhif_pkg::OP_TICK, 0, 0, 0, 0, 0));
      send_beat(make_cmd(lhif_pkg::OP_FADE_HUE, 16'h0133, 0, 16'd30, 0, 0)); // target above 255
      send_beat(make_cmd(lhif_pkg::OP_FADE_HUE, 16'hFFFF, 0, 16'd8, 0, 0));  // fade of a single tick
      send_beat(make_cmd(lhif_pkg::OP_OSC, 0, 0, 16'd100, 0, 8'd0));        // zero cycles
      send_beat(make_cmd(lhif_pkg::OP_OSC, 0, 0, 16'd0, 0, 8'd2));          // zero duration
      send_beat(make_cmd(lhif_pkg::OP_OSC, 0, 0, 16'hFFFF, 0, 8'd255));
      send_beat(make_cmd(lhif_pkg::OP_TICK, 0, 0, 0, 0, 0));
      send_beat(make_cmd(lhif_pkg::OP_STOP, 0, 0, 0, 0, 0));
      send_beat(make_cmd(3'd7, 16'hAAAA, 8'h55, 16'h5555, 1, 8'hAA));
      send_beat(make_cmd(lhif_pkg::OP_SET_INT, 0, 8'd1, 0, 0, 0));
      drain();

      // random phases across register settings, including both extremes
      for (phase = 0; phase < 4; phase++) begin
         csr_write(lhif_pkg::CSR_DIM_ENABLE, 8'(phase[0]));
         csr_write(lhif_pkg::CSR_TICK_MS, tick_set[phase]);
         quiet_mode = (phase == 2);
         if (phase == 1) hold_off_go = 1; // block fills up while we keep offering
         for (k = 0; k < 95; k++) send_beat(rand_cmd());
         if (phase == 3) begin
            // sender pause until all status has arrived, then a burst more
            req_valid <= 0;
            while (pending_count != 0) @(negedge clock);
            for (k = 0; k < 20; k++) send_beat(rand_cmd());
         end
         drain();
      end
      csr_write(lhif_pkg::CSR_TICK_MS, 8'd0); // zero interval acts as one
      for (k = 0; k < 10; k++) send_beat(rand_cmd());
      drain();

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
hdl/lhif_pkg.sv
hdl/lhif_div.sv
hdl/led_hue_intensity_fader.sv
verif/lhif_checker.sv
verif/tb_led_hue_intensity_fader.sv
